@@ rtl/assert_macros.svh @@
// assertion helpers, sampled on the rising edge of clk and held off during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// general clocked property
`define ASSERT_CLKED(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  `ASSERT_CLKED(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  `ASSERT_CLKED(lbl, (ante) |=> (cons), msg)

`endif

@@ rtl/stbs_pkg.sv @@
package stbs_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;

  // field widths
  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  // signed interval bound, holds -1 up to the largest index plus one
  localparam int POS_W = IDX_W + 2;

  // stream payload widths
  localparam int S_TDATA_W = 96;
  localparam int M_TDATA_W = 8;

  // s_tdata field offsets
  localparam int IDX_LSB  = 0;
  localparam int VAL_LSB  = IDX_LSB + IDX_W;
  localparam int LOW_LSB  = VAL_LSB + VAL_W;
  localparam int HIGH_LSB = LOW_LSB + IDX_W;
  localparam int KEY_LSB  = HIGH_LSB + IDX_W;

  // opcodes carried on s_tuser
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load_write;   // store entry_value at entry_index
    logic load_search;  // latch bounds and key, clear result
    logic start_probe;  // first midpoint, issue first read
    logic step_probe;   // narrow interval, issue next read
    logic found_set;    // probe matched
    logic out_load;     // move result into output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;        // interval empty before the first probe
    logic hit;          // probed entry equals key
    logic next_empty;   // narrowed interval would be empty
  } sts_t;

endpackage

@@ rtl/stbs_dpath.sv @@
`include "assert_macros.svh"

module stbs_dpath #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  stbs_pkg::cmd_t                      cmd,
  output stbs_pkg::sts_t                      sts,
  input  logic [stbs_pkg::IDX_W-1:0]          entry_index,
  input  logic signed [stbs_pkg::VAL_W-1:0]   entry_value,
  input  logic [stbs_pkg::IDX_W-1:0]          search_low,
  input  logic [stbs_pkg::IDX_W-1:0]          search_high,
  input  logic signed [stbs_pkg::VAL_W-1:0]   key,
  output logic [stbs_pkg::M_TDATA_W-1:0]      out_data
);

  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int POS_W = stbs_pkg::POS_W;
  localparam int VAL_W = stbs_pkg::VAL_W;
  localparam logic signed [POS_W:0] ONE_W = 1;

  logic signed [VAL_W-1:0] mem [TABLE_DEPTH];

  logic signed [POS_W-1:0] lo;
  logic signed [POS_W-1:0] hi;
  logic signed [POS_W-1:0] mid;
  logic signed [VAL_W-1:0] key_r;
  logic signed [VAL_W-1:0] rdata;
  logic                    found_r;

  logic signed [POS_W:0]   sum_start;
  logic signed [POS_W:0]   sum_up;
  logic signed [POS_W:0]   sum_dn;
  logic signed [POS_W-1:0] mid_start;
  logic signed [POS_W-1:0] mid_up;
  logic signed [POS_W-1:0] mid_dn;
  logic signed [POS_W-1:0] mid_next;
  logic signed [POS_W-1:0] hi_load;
  logic                    less;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic                    wr_ok;

  // saturate the upper bound to the last table index
  always_comb begin
    if (32'(search_high) > 32'(TABLE_DEPTH - 1)) begin
      hi_load = POS_W'(TABLE_DEPTH - 1);
    end else begin
      hi_load = POS_W'(search_high);
    end
  end

  assign wr_ok = 32'(entry_index) < 32'(TABLE_DEPTH);

  // both candidate midpoints come from registers, the compare only selects
  assign sum_start = (POS_W+1)'(lo) + (POS_W+1)'(hi);
  assign sum_up    = (POS_W+1)'(mid) + ONE_W + (POS_W+1)'(hi);
  assign sum_dn    = (POS_W+1)'(lo) + (POS_W+1)'(mid) - ONE_W;
  assign mid_start = POS_W'(sum_start >>> 1);
  assign mid_up    = POS_W'(sum_up >>> 1);
  assign mid_dn    = POS_W'(sum_dn >>> 1);

  assign less     = rdata < key_r;
  assign mid_next = cmd.start_probe ? mid_start : (less ? mid_up : mid_dn);
  assign rd_en    = cmd.start_probe | cmd.step_probe;
  assign rd_addr  = AW'(mid_next);

  assign sts.empty      = lo > hi;
  assign sts.hit        = rdata == key_r;
  assign sts.next_empty = less ? (mid >= hi) : (mid <= lo);

  always_ff @(posedge clk) begin
    if (cmd.load_write && wr_ok) begin
      mem[AW'(entry_index)] <= entry_value;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_search) begin
      lo    <= POS_W'(search_low);
      hi    <= hi_load;
      key_r <= key;
    end else if (cmd.step_probe) begin
      if (less) begin
        lo <= mid + POS_W'(1);
      end else begin
        hi <= mid - POS_W'(1);
      end
    end
    if (rd_en) begin
      mid <= mid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found_r  <= 1'b0;
      out_data <= '0;
    end else begin
      if (cmd.load_search) begin
        found_r <= 1'b0;
      end else if (cmd.found_set) begin
        found_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_data <= stbs_pkg::M_TDATA_W'(found_r);
      end
    end
  end

  `ASSERT_IMPL(a_mid_in_range, cmd.step_probe, (mid >= lo) && (mid <= hi),
    "probe index outside the search interval")
  `ASSERT_NEXT(a_interval_shrinks, cmd.step_probe, (hi - lo) < $past(hi - lo),
    "search interval did not narrow")

endmodule

@@ rtl/stbs_ctrl.sv @@
`include "assert_macros.svh"

module stbs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic           opcode,
  output logic           m_tvalid,
  input  logic           m_tready,
  output stbs_pkg::cmd_t cmd,
  input  stbs_pkg::sts_t sts
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_PROBE = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign s_tready = state == ST_IDLE;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (opcode == stbs_pkg::OP_SEARCH) begin
            cmd.load_search = 1'b1;
            state_next      = ST_START;
          end else begin
            cmd.load_write = 1'b1;
          end
        end
      end
      ST_START: begin
        cmd.start_probe = 1'b1;
        state_next      = sts.empty ? ST_DONE : ST_PROBE;
      end
      ST_PROBE: begin
        if (sts.hit) begin
          cmd.found_set = 1'b1;
          state_next    = ST_DONE;
        end else if (sts.next_empty) begin
          state_next = ST_DONE;
        end else begin
          cmd.step_probe = 1'b1;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `ASSERT_NEXT(a_search_starts, accept && (opcode == stbs_pkg::OP_SEARCH),
    state == ST_START, "accepted search did not start")
  `ASSERT_CLKED(a_result_from_done, $rose(m_tvalid) |-> $past(state == ST_DONE),
    "result raised outside the done state")

endmodule

@@ rtl/sorted_table_binary_search.sv @@
// Binary search over a sorted table of TABLE_DEPTH signed 32-bit entries held in
// a single-port-read block memory. A transaction with s_tuser = 0 writes
// entry_value at entry_index and gives no result (an index at or
// beyond TABLE_DEPTH is dropped). A transaction with s_tuser = 1 searches the
// inclusive interval search_low..search_high (search_high clamped to the last
// index) for key and returns one result transaction with found in m_tdata[0].
// A search makes at most floor(log2(interval length)) + 1 probes, and the next
// transaction is taken in the cycle after its result is loaded into the output
// register. The memory read port delivers one registered probe per cycle. One
// search is in flight at a time; a finished result may wait in the output
// register while the next item is taken.
// Entries must be written before any search probes them.

module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // s_tdata: entry_index[9:0], entry_value[41:10], search_low[51:42],
  //          search_high[61:52], key[93:62], zero fill[95:94]
  input  logic [stbs_pkg::S_TDATA_W-1:0]    s_tdata,
  // s_tuser: opcode[0] (0 write, 1 search)
  input  logic                              s_tuser,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // m_tdata: found[0], zero fill[7:1]
  output logic [stbs_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready
);

  stbs_pkg::cmd_t cmd;
  stbs_pkg::sts_t sts;

  // sequencer: accepts transactions, runs the probe loop, owns m_tvalid
  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .opcode   (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // table memory, interval bounds, midpoint and key compare
  stbs_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .entry_index (s_tdata[stbs_pkg::IDX_LSB  +: stbs_pkg::IDX_W]),
    .entry_value (s_tdata[stbs_pkg::VAL_LSB  +: stbs_pkg::VAL_W]),
    .search_low  (s_tdata[stbs_pkg::LOW_LSB  +: stbs_pkg::IDX_W]),
    .search_high (s_tdata[stbs_pkg::HIGH_LSB +: stbs_pkg::IDX_W]),
    .key         (s_tdata[stbs_pkg::KEY_LSB  +: stbs_pkg::VAL_W]),
    .out_data    (m_tdata)
  );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int IDX_W = stbs_pkg::IDX_W;
  localparam int VAL_W = stbs_pkg::VAL_W;
  localparam int DEPTH = stbs_pkg::TABLE_DEPTH_DEF;
  localparam int RANDOM_OPS = 900;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;

  // percentage of cycles in which each side holds off, per pacing phase
  localparam int SEND_IDLE [3] = '{17, 56, 0};
  localparam int TAKE_IDLE [3] = '{56, 17, 0};

  typedef struct {
    logic                    opcode;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] val;
    logic [IDX_W-1:0]        lo;
    logic [IDX_W-1:0]        hi;
    logic signed [VAL_W-1:0] key;
    int                      pace;
    bit                      drain;  // hold back until all searches have answered
  } table_op_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic [stbs_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic                           s_tuser = 1'b0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [stbs_pkg::M_TDATA_W-1:0] m_tdata;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;

  table_op_t table_ops [$];
  logic      found_expected [$];

  // table as the block should hold it, updated on accepted writes
  logic signed [VAL_W-1:0] mirror_entry [DEPTH];
  // table as planned by the stimulus, used to keep searches on written entries
  logic signed [VAL_W-1:0] plan_entry [DEPTH];
  bit                      plan_written [DEPTH];
  int                      plan_pace = 2;
  bit                      plan_drain = 1'b0;

  int shown_n = 0;
  int taken_n = 0;
  int cur_pace = 2;
  int quiet = 0;
  int fails = 0;
  table_op_t took;
  logic      want;

  sorted_table_binary_search u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // midpoint probing rounded down, high bound clamped to the last index
  function automatic logic search_found(input logic [IDX_W-1:0] lo_f,
                                        input logic [IDX_W-1:0] hi_f,
                                        input logic signed [VAL_W-1:0] key_f);
    int lo;
    int hi;
    int mid;
    lo = lo_f;
    hi = hi_f;
    if (hi > DEPTH - 1) hi = DEPTH - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (mirror_entry[mid] == key_f) return 1'b1;
      if (mirror_entry[mid] < key_f) lo = mid + 1;
      else hi = mid - 1;
    end
    return 1'b0;
  endfunction

  task automatic push_op(input table_op_t op);
    op.pace = plan_pace;
    op.drain = plan_drain;
    plan_drain = 1'b0;
    table_ops.push_back(op);
  endtask

  // unused fields carry random junk
  task automatic push_write(input logic [IDX_W-1:0] idx, input logic signed [VAL_W-1:0] val);
    table_op_t op;
    op.opcode = stbs_pkg::OP_WRITE;
    op.idx = idx;
    op.val = val;
    op.lo = IDX_W'($urandom);
    op.hi = IDX_W'($urandom);
    op.key = $urandom;
    push_op(op);
    plan_entry[idx] = val;
    plan_written[idx] = 1'b1;
  endtask

  task automatic push_search(input logic [IDX_W-1:0] lo, input logic [IDX_W-1:0] hi,
                             input logic signed [VAL_W-1:0] key);
    table_op_t op;
    op.opcode = stbs_pkg::OP_SEARCH;
    op.idx = IDX_W'($urandom);
    op.val = $urandom;
    op.lo = lo;
    op.hi = hi;
    op.key = key;
    push_op(op);
  endtask

  task automatic push_empty_search();
    int lo;
    lo = $urandom_range(DEPTH - 1, 1);
    push_search(IDX_W'(lo), IDX_W'($urandom_range(lo - 1, 0)), $urandom);
  endtask

  // search inside the written stretch around anchor, so no blank entry is probed
  task automatic push_span_search(input int anchor);
    int a;
    int b;
    int lo;
    int hi;
    int pick;
    logic signed [VAL_W-1:0] k;
    a = anchor;
    b = anchor;
    while (a > 0 && plan_written[a-1]) a--;
    while (b < DEPTH - 1 && plan_written[b+1]) b++;
    if ($urandom_range(3, 0) == 0) begin
      lo = a;
      hi = b;
    end else begin
      lo = $urandom_range(anchor, a);
      hi = $urandom_range(b, anchor);
    end
    k = plan_entry[$urandom_range(hi, lo)];
    pick = $urandom_range(9, 0);
    if (pick == 5 || pick == 6) k = k + 1;
    else if (pick == 7) k = k - 1;
    else if (pick > 7) k = $urandom;
    push_search(IDX_W'(lo), IDX_W'(hi), k);
  endtask

  initial begin
    int n_directed;
    int n_rand;
    int kind;
    int len;
    int base;
    int mode;
    int tries;
    int anchor;
    int unsigned step_max;
    longint v;
    logic signed [VAL_W-1:0] r32;

    // directed: extremes of value and index, hits at both ends, misses, empty
    // and single-entry intervals, then a broken order
    push_write(0, VAL_MIN);
    push_write(1, -1000);
    push_write(2, 0);
    push_write(3, 1);
    push_write(4, 5000);
    push_write(5, VAL_MAX);
    push_write(1022, -7);
    push_write(1023, VAL_MAX);
    push_search(0, 5, VAL_MIN);
    push_search(0, 5, VAL_MAX);
    push_search(0, 5, VAL_MIN + 1);
    push_search(0, 5, 2);
    push_search(0, 5, 1);
    push_search(3, 2, 1);
    push_search(2, 2, 0);
    push_search(1023, 1023, VAL_MAX);
    push_search(1022, 1023, -7);
    push_search(1023, 0, VAL_MAX);
    push_write(2, 9999);
    push_search(0, 5, 9999);
    push_search(0, 5, 1);
    n_directed = table_ops.size();

    n_rand = 0;
    while (n_rand < RANDOM_OPS) begin
      kind = n_rand * 3 / RANDOM_OPS;
      if (kind > 2) kind = 2;
      if (kind != plan_pace || n_rand == 0) plan_drain = 1'b1;
      plan_pace = kind;
      if ($urandom_range(99, 0) == 0) plan_drain = 1'b1;

      kind = $urandom_range(99, 0);
      if (kind < 55) begin
        // ascending run then a few searches over it
        len = ($urandom_range(9, 0) == 0) ? $urandom_range(128, 25) : $urandom_range(24, 1);
        base = $urandom_range(DEPTH - len, 0);
        mode = $urandom_range(2, 0);
        step_max = (mode == 0) ? 4 : (mode == 1) ? (1 << 20) : (1 << 28);
        r32 = $urandom;
        v = ($urandom_range(3, 0) == 0) ? longint'(VAL_MIN) : longint'(r32);
        for (int i = 0; i < len; i++) begin
          if (v > 2147483647) v = 2147483647;
          push_write(IDX_W'(base + i), v[31:0]);
          v = v + longint'($urandom_range(step_max, 0));
        end
        for (int i = $urandom_range(5, 1); i > 0; i--)
          push_span_search($urandom_range(base + len - 1, base));
      end else if (kind < 80) begin
        anchor = -1;
        for (tries = 0; tries < 8 && anchor < 0; tries++) begin
          base = $urandom_range(DEPTH - 1, 0);
          if (plan_written[base]) anchor = base;
        end
        if (anchor >= 0) push_span_search(anchor);
        else push_empty_search();
      end else if (kind < 92) begin
        // stray write, may break the ascending order
        push_write(IDX_W'($urandom), $urandom);
      end else begin
        push_empty_search();
      end
      n_rand = table_ops.size() - n_directed;
    end

    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (table_ops.size() != 0 || found_expected.size() != 0 || s_tvalid)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // driver: stimulus and back-pressure change on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99, 0) >= TAKE_IDLE[cur_pace]);
      if (!s_tvalid || taken_n == shown_n) begin
        if (table_ops.size() != 0 && !(table_ops[0].drain && found_expected.size() != 0)
            && $urandom_range(99, 0) >= SEND_IDLE[table_ops[0].pace]) begin
          s_tvalid <= 1'b1;
          s_tuser <= table_ops[0].opcode;
          s_tdata <= {2'b00, table_ops[0].key, table_ops[0].hi, table_ops[0].lo,
                      table_ops[0].val, table_ops[0].idx};
          shown_n <= shown_n + 1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: transactions on both sides, sampled on the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        took = table_ops.pop_front();
        taken_n <= taken_n + 1;
        cur_pace <= took.pace;
        if (took.opcode == stbs_pkg::OP_WRITE) begin
          if (took.idx < DEPTH) mirror_entry[took.idx] = took.val;
        end else begin
          found_expected.push_back(search_found(took.lo, took.hi, took.key));
        end
      end
      if (m_tvalid && m_tready) begin
        if (found_expected.size() == 0) begin
          $error("found: none expected, got %0d", m_tdata[0]);
          fails++;
        end else begin
          want = found_expected.pop_front();
          if (m_tdata[0] !== want) begin
            $error("found: expected %0d, got %0d", want, m_tdata[0]);
            fails++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

endmodule
